[design/assert_macros.svh]
// Assertion macros used by the sequencer of the ordered list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define OLE_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");

// A condition that must hold whenever the antecedent holds.
`define OLE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

`endif

[design/olist_pkg.sv]
// Shared types and constants of the ordered list engine.
package olist_pkg;

   // List capacity and derived widths.
   localparam int DEPTH  = 64;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Fixed field widths of the transaction payloads.
   localparam int FUNC_W = 3;
   localparam int POS_W  = 7;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;

   // Width used to compare a requested position with the fill count.
   localparam int PCMP_W = (POS_W > CNT_W + 1) ? POS_W : CNT_W + 1;

   typedef enum logic [FUNC_W-1:0] {
      FN_INS_FRONT = 3'd0,
      FN_APPEND    = 3'd1,
      FN_INS_POS   = 3'd2,
      FN_FIND      = 3'd3,
      FN_DELETE    = 3'd4,
      FN_DUMP      = 3'd5
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_POS   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_PUT,
      S_SCAN,
      S_FIN,
      S_RESP
   } state_type;

   // One result transaction.
   typedef struct packed {
      status_type              status;
      logic [POS_W-1:0]        found_position;
      logic signed [VAL_W-1:0] entry_value;
      logic [POS_W-1:0]        entry_count;
      logic                    last;
   } result_type;

endpackage

[design/olist_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module olist_ram #(
   parameter int DATA_W = 32,
   parameter int WORDS  = 64,
   parameter int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/olist_seq.sv]
// Operation sequencer: walks the entry RAM to shift, scan, compact and dump.
`include "assert_macros.svh"

module olist_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [olist_pkg::FUNC_W-1:0]       req_func,
   input  logic [olist_pkg::POS_W-1:0]        req_position,
   input  logic signed [olist_pkg::VAL_W-1:0] req_value,
   input  logic                               out_free,
   output logic                               res_valid,
   output olist_pkg::result_type              res,
   output logic                               ram_wr_en,
   output logic [olist_pkg::IDX_W-1:0]        ram_wr_addr,
   output logic [olist_pkg::VAL_W-1:0]        ram_wr_data,
   output logic                               ram_rd_en,
   output logic [olist_pkg::IDX_W-1:0]        ram_rd_addr,
   input  logic [olist_pkg::VAL_W-1:0]        ram_rd_data
);
   import olist_pkg::*;

   state_type               state_ff, state_in;
   func_type                func_ff, func_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        rd_left_ff, rd_left_in;
   logic                    p_vld_ff, p_vld_in;
   logic [IDX_W-1:0]        p_addr_ff, p_addr_in;
   logic [CNT_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic                    held_vld_ff, held_vld_in;
   logic [CNT_W-1:0]        held_pos_ff, held_pos_in;
   status_type              fin_status_ff, fin_status_in;
   logic [CNT_W-1:0]        fin_pos_ff, fin_pos_in;

   func_type                req_fn;
   logic                    accept;
   logic                    is_insert;
   logic                    is_full;
   logic [PCMP_W-1:0]       pos_ext;
   logic [PCMP_W-1:0]       pos_m1;
   logic [PCMP_W-1:0]       cnt_p1;
   logic                    bad_pos;
   logic [IDX_W-1:0]        ins_idx;
   logic                    need_shift;
   logic                    match;
   logic                    scan_busy;
   logic                    can_consume;
   logic                    consume;
   logic                    issue;
   logic                    drained;
   logic [CNT_W-1:0]        p_pos;

   // Request decode.
   assign req_fn    = func_type'(req_func);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign is_insert = (req_fn == FN_INS_FRONT) || (req_fn == FN_APPEND) ||
                      (req_fn == FN_INS_POS);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign pos_ext   = PCMP_W'(req_position);
   assign pos_m1    = pos_ext - PCMP_W'(1);
   assign cnt_p1    = PCMP_W'(count_ff) + PCMP_W'(1);
   assign bad_pos   = (req_fn == FN_INS_POS) &&
                      ((pos_ext == '0) || (pos_ext > cnt_p1));

   // Index that the new value lands on.
   always_comb begin
      case (req_fn)
         FN_INS_FRONT: ins_idx = '0;
         FN_APPEND:    ins_idx = count_ff[IDX_W-1:0];
         FN_INS_POS:   ins_idx = pos_m1[IDX_W-1:0];
         default:      ins_idx = '0;
      endcase
   end
   assign need_shift = (count_ff > CNT_W'(ins_idx));

   // Read pipeline: at most one RAM read in flight, held until it can be consumed.
   assign match     = (ram_rd_data == val_ff);
   assign scan_busy = (state_ff == S_SHIFT) || (state_ff == S_SCAN);
   assign p_pos     = CNT_W'(p_addr_ff) + CNT_W'(1);

   always_comb begin
      case (func_ff)
         FN_FIND: can_consume = !match || !held_vld_ff || out_free;
         FN_DUMP: can_consume = out_free;
         default: can_consume = 1'b1;
      endcase
   end

   assign consume = scan_busy && p_vld_ff && can_consume;
   assign issue   = scan_busy && (!p_vld_ff || consume) && (rd_left_ff != '0);
   assign drained = (rd_left_ff == '0) && !p_vld_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_fn)
                  FN_INS_FRONT, FN_APPEND, FN_INS_POS: begin
                     if (is_full || bad_pos) begin
                        state_in = S_RESP;
                     end else if (need_shift) begin
                        state_in = S_SHIFT;
                     end else begin
                        state_in = S_PUT;
                     end
                  end
                  FN_FIND, FN_DELETE, FN_DUMP: begin
                     state_in = (count_ff == '0) ? S_FIN : S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SHIFT: begin
            if (drained) begin
               state_in = S_PUT;
            end
         end
         S_SCAN: begin
            if (drained) begin
               state_in = S_FIN;
            end
         end
         S_PUT:   state_in = S_RESP;
         S_FIN: begin
            if ((func_ff == FN_DUMP) && (count_ff != '0)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs: handshake, RAM ports and result transactions.
   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      ram_rd_en   = issue;
      ram_rd_addr = rd_ptr_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = ram_rd_data;
      res_valid   = 1'b0;
      res         = '{status: ST_OK, found_position: '0, entry_value: '0,
                      entry_count: POS_W'(count_ff), last: 1'b0};
      case (state_ff)
         S_SHIFT: begin
            // Move the entry just read one place toward the back.
            ram_wr_en   = consume;
            ram_wr_addr = p_addr_ff + IDX_W'(1);
         end
         S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = val_ff;
         end
         S_SCAN: begin
            case (func_ff)
               FN_DELETE: begin
                  // Keep entries that differ, closing up the gaps.
                  ram_wr_en   = consume && !match;
                  ram_wr_addr = wr_ptr_ff[IDX_W-1:0];
               end
               FN_FIND: begin
                  // A new match releases the one held before it.
                  res_valid          = consume && match && held_vld_ff;
                  res.found_position = POS_W'(held_pos_ff);
                  res.entry_value    = val_ff;
               end
               FN_DUMP: begin
                  res_valid          = consume;
                  res.found_position = POS_W'(p_pos);
                  res.entry_value    = ram_rd_data;
                  res.last           = (p_pos == count_ff);
               end
               default: res_valid = 1'b0;
            endcase
         end
         S_RESP: begin
            res_valid          = out_free;
            res.status         = fin_status_ff;
            res.found_position = POS_W'(fin_pos_ff);
            res.entry_value    = (fin_pos_ff != '0) ? val_ff : '0;
            res.last           = 1'b1;
         end
         default: res_valid = 1'b0;
      endcase
   end

   // Next values of the datapath registers.
   always_comb begin
      func_in       = func_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_left_in    = rd_left_ff;
      p_vld_in      = p_vld_ff;
      p_addr_in     = p_addr_ff;
      wr_ptr_in     = wr_ptr_ff;
      held_vld_in   = held_vld_ff;
      held_pos_in   = held_pos_ff;
      fin_status_in = fin_status_ff;
      fin_pos_in    = fin_pos_ff;

      if (accept) begin
         func_in     = req_fn;
         val_in      = req_value;
         idx_in      = ins_idx;
         p_vld_in    = 1'b0;
         wr_ptr_in   = '0;
         held_vld_in = 1'b0;
         fin_pos_in  = '0;
         if (is_insert && is_full) begin
            fin_status_in = ST_FULL;
         end else if (bad_pos) begin
            fin_status_in = ST_BAD_POS;
         end else begin
            fin_status_in = ST_OK;
         end
         if (is_insert) begin
            // Shift reads run from the back down to the insert index.
            rd_ptr_in  = IDX_W'(count_ff - CNT_W'(1));
            rd_left_in = count_ff - CNT_W'(ins_idx);
         end else begin
            rd_ptr_in  = '0;
            rd_left_in = count_ff;
         end
      end

      if (issue) begin
         rd_left_in = rd_left_ff - CNT_W'(1);
         p_addr_in  = rd_ptr_ff;
         rd_ptr_in  = (state_ff == S_SHIFT) ? rd_ptr_ff - IDX_W'(1)
                                            : rd_ptr_ff + IDX_W'(1);
      end
      if (scan_busy) begin
         p_vld_in = issue || (p_vld_ff && !consume);
      end

      if (consume && (state_ff == S_SCAN)) begin
         if ((func_ff == FN_DELETE) && !match) begin
            wr_ptr_in = wr_ptr_ff + CNT_W'(1);
         end
         if ((func_ff == FN_FIND) && match) begin
            held_vld_in = 1'b1;
            held_pos_in = p_pos;
         end
      end

      case (state_ff)
         S_PUT: count_in = count_ff + CNT_W'(1);
         S_FIN: begin
            case (func_ff)
               FN_FIND: begin
                  fin_status_in = held_vld_ff ? ST_OK : ST_NOT_FOUND;
                  fin_pos_in    = held_vld_ff ? held_pos_ff : '0;
               end
               FN_DELETE: begin
                  count_in      = wr_ptr_ff;
                  fin_status_in = (wr_ptr_ff != count_ff) ? ST_OK : ST_NOT_FOUND;
               end
               default: fin_status_in = ST_NOT_FOUND;
            endcase
         end
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         p_vld_ff    <= 1'b0;
         rd_left_ff  <= '0;
         held_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         p_vld_ff    <= p_vld_in;
         rd_left_ff  <= rd_left_in;
         held_vld_ff <= held_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      rd_ptr_ff     <= rd_ptr_in;
      p_addr_ff     <= p_addr_in;
      wr_ptr_ff     <= wr_ptr_in;
      held_pos_ff   <= held_pos_in;
      fin_status_ff <= fin_status_in;
      fin_pos_ff    <= fin_pos_in;
   end

   // Checks on the sequencer's own bookkeeping.
   `OLE_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `OLE_ASSERT_IMPLY(a_res_has_slot, clock, reset, res_valid, out_free)
   `OLE_ASSERT_IMPLY(a_idle_drained, clock, reset, state_ff == S_IDLE, !p_vld_ff)
   `OLE_ASSERT_IMPLY(a_put_has_room, clock, reset, state_ff == S_PUT, !is_full)

endmodule

[design/ordered_list_engine_core.sv]
// Ordered list of signed words in one RAM, with front/back/positional insert,
// find, delete-all and dump. One transaction is handled at a time. The
// entries sit in a single synchronous RAM with one read and one write port,
// and every operation that walks it does so one entry per cycle while the
// result side does not stall. A new request is taken once the previous one
// has handed over its final result to the output register. The RAM needs no
// clearing after reset: only entries below the fill count are ever read.
module ordered_list_engine_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [olist_pkg::FUNC_W-1:0]       req_func,
   input  logic [olist_pkg::POS_W-1:0]        req_position,
   input  logic signed [olist_pkg::VAL_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [olist_pkg::STAT_W-1:0]       rsp_status,
   output logic [olist_pkg::POS_W-1:0]        rsp_found_position,
   output logic signed [olist_pkg::VAL_W-1:0] rsp_entry_value,
   output logic [olist_pkg::POS_W-1:0]        rsp_entry_count,
   output logic                               rsp_last
);
   import olist_pkg::*;

   logic             out_free;
   logic             res_valid;
   result_type       res;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [VAL_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [VAL_W-1:0] ram_rd_data;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;

   olist_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_position (req_position),
      .req_value    (req_value),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

   olist_ram #(
      .DATA_W (VAL_W),
      .WORDS  (DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register: loads whenever it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_data_ff.status;
   assign rsp_found_position = rsp_data_ff.found_position;
   assign rsp_entry_value    = rsp_data_ff.entry_value;
   assign rsp_entry_count    = rsp_data_ff.entry_count;
   assign rsp_last           = rsp_data_ff.last;

endmodule

[verif/ordered_list_engine_core_tb.sv]
// Testbench for the ordered list engine core: directed, full-list, backpressure and random tests.
module ordered_list_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import olist_pkg::*;

   // Function codes the block ignores.
   localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd6;
   localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd7;

   localparam int RANDOM_ITEMS    = 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = DEPTH + 16;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [FUNC_W-1:0]       req_func;
   logic [POS_W-1:0]        req_position;
   logic signed [VAL_W-1:0] req_value;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [STAT_W-1:0]       rsp_status;
   logic [POS_W-1:0]        rsp_found_position;
   logic signed [VAL_W-1:0] rsp_entry_value;
   logic [POS_W-1:0]        rsp_entry_count;
   logic                    rsp_last;

   // Shadow copy of the list, in order, and the results still owed by the block.
   logic signed [VAL_W-1:0] list_shadow[$];
   result_type              expected_results[$];

   int fail_count     = 0;
   bit idle_enabled   = 1'b1;
   bit hold_off_start = 1'b0;

   ordered_list_engine_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_last           (rsp_last)
   );

   // Free-running clock, 2 ns period.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Data value: often one already in the list, else small, extreme or fully random.
   function automatic logic signed [VAL_W-1:0] pick_value(bit prefer_list);
      int r;
      r = $urandom_range(0, 99);
      if (prefer_list && list_shadow.size() != 0 && r < 60)
         return list_shadow[$urandom_range(0, list_shadow.size() - 1)];
      if (r < 70) return int'($urandom_range(0, 6)) - 3;
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end
      return $urandom();
   endfunction

   // Queue one expected result; the count reflects the list after the operation.
   function automatic void expect_result(status_type st, int pos,
                                         logic signed [VAL_W-1:0] val, bit is_last);
      result_type r;
      int         cnt;
      cnt              = list_shadow.size();
      r.status         = st;
      r.found_position = pos[POS_W-1:0];
      r.entry_value    = val;
      r.entry_count    = cnt[POS_W-1:0];
      r.last           = is_last;
      expected_results.insert(expected_results.size(), r);
   endfunction

   // Apply one accepted operation to the shadow list and queue its results.
   function automatic void predict_list_op(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                                           logic signed [VAL_W-1:0] val);
      logic signed [VAL_W-1:0] kept[$];
      int                      hit_total;
      int                      seen;
      bit                      removed;
      hit_total = 0;
      seen      = 0;
      case (fn)
         FN_INS_FRONT, FN_APPEND, FN_INS_POS: begin
            // A full list is reported before the position is looked at.
            if (list_shadow.size() >= DEPTH) begin
               expect_result(ST_FULL, 0, '0, 1'b1);
            end else if (fn == FN_INS_FRONT) begin
               list_shadow.push_front(val);
               expect_result(ST_OK, 0, '0, 1'b1);
            end else if (fn == FN_APPEND) begin
               list_shadow.insert(list_shadow.size(), val);
               expect_result(ST_OK, 0, '0, 1'b1);
            end else if (pos < 1 || pos > list_shadow.size() + 1) begin
               expect_result(ST_BAD_POS, 0, '0, 1'b1);
            end else begin
               list_shadow.insert(pos - 1, val);
               expect_result(ST_OK, 0, '0, 1'b1);
            end
         end
         FN_FIND: begin
            foreach (list_shadow[i])
               if (list_shadow[i] == val) hit_total++;
            if (hit_total == 0) begin
               expect_result(ST_NOT_FOUND, 0, '0, 1'b1);
            end else begin
               foreach (list_shadow[i]) begin
                  if (list_shadow[i] == val) begin
                     seen++;
                     expect_result(ST_OK, i + 1, val, seen == hit_total);
                  end
               end
            end
         end
         FN_DELETE: begin
            foreach (list_shadow[i])
               if (list_shadow[i] != val) kept.insert(kept.size(), list_shadow[i]);
            removed     = (kept.size() != list_shadow.size());
            list_shadow = kept;
            expect_result(removed ? ST_OK : ST_NOT_FOUND, 0, '0, 1'b1);
         end
         FN_DUMP: begin
            if (list_shadow.size() == 0) begin
               expect_result(ST_NOT_FOUND, 0, '0, 1'b1);
            end else begin
               foreach (list_shadow[i])
                  expect_result(ST_OK, i + 1, list_shadow[i], i == list_shadow.size() - 1);
            end
         end
         default: begin
            // Unused codes produce nothing.
         end
      endcase
   endfunction

   // Offer one transaction after an optional gap and hold it until accepted.
   task automatic send_item(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                            logic signed [VAL_W-1:0] val);
      int gap;
      gap = idle_enabled ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= fn;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_list_op(fn, pos, val);
   endtask

   // Record a failure; only the first few are printed in full.
   task automatic report_mismatch(string why, bit have_want, result_type want);
      fail_count++;
      if (fail_count <= 10) begin
         if (have_want)
            $display("%0t mismatch, %s: expected st=%0d pos=%0d val=%0d cnt=%0d last=%0d",
                     $realtime, why, want.status, want.found_position, want.entry_value,
                     want.entry_count, want.last);
         else
            $display("%0t mismatch, %s: nothing expected", $realtime, why);
         $display("   actual st=%0d pos=%0d val=%0d cnt=%0d last=%0d",
                  rsp_status, rsp_found_position, rsp_entry_value, rsp_entry_count, rsp_last);
      end
   endtask

   // Compare every accepted result transaction with the oldest expectation.
   always @(posedge clock) begin : check_results
      result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            want = '0;
            report_mismatch("unexpected result", 1'b0, want);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status || rsp_found_position !== want.found_position ||
                rsp_entry_value !== want.entry_value ||
                rsp_entry_count !== want.entry_count || rsp_last !== want.last)
               report_mismatch("field differs", 1'b1, want);
         end
      end
   end

   // Result side: random stalls, plus one long hold-off when a test asks for it.
   initial begin : drive_rsp_ready
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_start) begin
            hold_off_start = 1'b0;
            hold_left      = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_enabled) stall_left = pick_gap();
         end
      end
   end

   // Empty-list answers, bad positions, inserts at both ends, duplicates, unused codes.
   task automatic test_edge_cases();
      send_item(FN_DUMP, 7'd0, 32'sd0);
      send_item(FN_FIND, 7'd0, 32'sd0);
      send_item(FN_DELETE, 7'd0, 32'sd0);
      send_item(FN_INS_POS, 7'd0, 32'sd11);
      send_item(FN_INS_POS, 7'd2, 32'sd11);
      send_item(FN_INS_POS, 7'd127, 32'sd11);
      send_item(FN_INS_POS, 7'd1, 32'sd42);
      send_item(FN_INS_FRONT, 7'd127, 32'sh8000_0000);
      send_item(FN_APPEND, 7'd64, 32'sh7fff_ffff);
      send_item(FN_INS_POS, 7'd2, -32'sd1);
      send_item(FN_INS_POS, 7'd5, 32'sd0);
      send_item(FN_APPEND, 7'd0, 32'sd42);
      send_item(FN_INS_FRONT, 7'd0, 32'sd42);
      send_item(FN_FIND, 7'd0, 32'sd42);
      send_item(FN_FIND, 7'd0, 32'sd7);
      send_item(FN_DUMP, 7'd0, 32'sd0);
      send_item(FN_INS_POS, 7'd64, 32'sd5);
      send_item(FN_UNUSED_A, 7'd1, 32'sd42);
      send_item(FN_UNUSED_B, 7'd127, 32'sh7fff_ffff);
      send_item(FN_DELETE, 7'd0, 32'sd42);
      send_item(FN_DELETE, 7'd0, 32'sd42);
      send_item(FN_FIND, 7'd0, 32'sh7fff_ffff);
      send_item(FN_INS_POS, 7'd1, 32'sh5555_aaaa);
      send_item(FN_DUMP, 7'd0, 32'sd0);
   endtask

   // Fill the list to capacity, probe every insert form, then scan it and delete the values 5, 6 and 7.
   task automatic test_full_list();
      logic signed [VAL_W-1:0] val;
      while (list_shadow.size() < DEPTH) begin
         val = ($urandom_range(0, 1) == 0) ? int'($urandom_range(5, 7)) : $urandom();
         case ($urandom_range(0, 2))
            0: send_item(FN_APPEND, 7'd0, val);
            1: send_item(FN_INS_FRONT, 7'd0, val);
            default: send_item(FN_INS_POS,
                               POS_W'($urandom_range(1, list_shadow.size() + 1)), val);
         endcase
      end
      send_item(FN_INS_FRONT, 7'd0, 32'sd1);
      send_item(FN_APPEND, 7'd0, 32'sd1);
      send_item(FN_INS_POS, 7'd0, 32'sd1);
      send_item(FN_INS_POS, 7'd127, 32'sd1);
      send_item(FN_INS_POS, 7'd1, 32'sd1);
      send_item(FN_FIND, 7'd0, 32'sd5);
      send_item(FN_DUMP, 7'd0, 32'sd0);
      send_item(FN_DELETE, 7'd0, 32'sd5);
      send_item(FN_DELETE, 7'd0, 32'sd6);
      send_item(FN_DELETE, 7'd0, 32'sd7);
      send_item(FN_DUMP, 7'd0, 32'sd0);
   endtask

   // Hold the result side off while requests keep coming, so the input stalls.
   task automatic test_backpressure();
      hold_off_start = 1'b1;
      repeat (4) send_item(FN_APPEND, 7'd0, pick_value(1'b0));
      send_item(FN_DUMP, 7'd0, 32'sd0);
      send_item(FN_FIND, 7'd0, pick_value(1'b1));
      send_item(FN_INS_FRONT, 7'd0, pick_value(1'b0));
      send_item(FN_DUMP, 7'd0, 32'sd0);
   endtask

   // Random mix, weighted toward valid inserts, with one stretch free of idling.
   task automatic test_random_mix();
      int sent;
      int r;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idle_enabled = !(sent >= 8 && sent < 16);
         r = $urandom_range(0, 99);
         if (r < 18)
            send_item(FN_INS_FRONT, POS_W'($urandom_range(0, 127)), pick_value(1'b0));
         else if (r < 34)
            send_item(FN_APPEND, POS_W'($urandom_range(0, 127)), pick_value(1'b0));
         else if (r < 50)
            send_item(FN_INS_POS, POS_W'($urandom_range(1, list_shadow.size() + 1)),
                      pick_value(1'b0));
         else if (r < 57)
            send_item(FN_INS_POS, ($urandom_range(0, 2) == 0) ? POS_W'(0) :
                      POS_W'($urandom_range(list_shadow.size() + 2, 127)),
                      pick_value(1'b0));
         else if (r < 72)
            send_item(FN_FIND, POS_W'($urandom_range(0, 127)), pick_value(1'b1));
         else if (r < 84)
            send_item(FN_DELETE, POS_W'($urandom_range(0, 127)), pick_value(1'b1));
         else if (r < 93)
            send_item(FN_DUMP, POS_W'($urandom_range(0, 127)), $urandom());
         else begin
            // Ignored codes; not counted toward the random total.
            send_item(($urandom_range(0, 1) == 0) ? FN_UNUSED_A : FN_UNUSED_B,
                      POS_W'($urandom_range(0, 127)), $urandom());
            sent--;
         end
         sent++;
      end
      idle_enabled = 1'b1;
   endtask

   // Reset, the tests in turn, drain, verdict.
   initial begin : run_tests
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = FN_INS_FRONT;
      req_position = '0;
      req_value    = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_full_list();
      test_backpressure();
      test_random_mix();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/olist_pkg.sv
design/olist_ram.sv
design/olist_seq.sv
design/ordered_list_engine_core.sv
verif/ordered_list_engine_core_tb.sv
